/* design/pngu_pkg.sv */
// ----------------------------------------------------------------------------
// pngu_pkg
// Shared types and constants for the PNG scanline unfilter block.
// ----------------------------------------------------------------------------
package pngu_pkg;

    localparam int DEF_MAX_WIDTH       = 2048;
    localparam int DEF_BYTES_PER_PIXEL = 4;

    localparam int BYTE_W     = 8;
    localparam int CFG_WIDTH_W  = 12;
    localparam int CFG_HEIGHT_W = 16;
    localparam int CFG_DATA_W = 16;
    localparam int ROW_CNT_W  = 16;

    // Filter codes as carried in the stream
    typedef enum logic [2:0] {
        FILT_NONE  = 3'd0,
        FILT_SUB   = 3'd1,
        FILT_UP    = 3'd2,
        FILT_AVG   = 3'd3,
        FILT_PAETH = 3'd4
    } t_filter;

    localparam logic [BYTE_W-1:0] FILT_MAX_CODE = 8'd4;

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } t_cfg_reg;

    // Per-byte control handed to the predictor
    typedef struct packed {
        t_filter filter;
        logic    bad;
    } t_pred_ctl;

endpackage

/* design/pngu_predict.sv */
// ----------------------------------------------------------------------------
// pngu_predict
// Rebuild one filtered byte from its left, up and upper-left neighbors.
// ----------------------------------------------------------------------------
module pngu_predict
    import pngu_pkg::*;
(
    input  t_pred_ctl         i_ctl,
    input  logic [BYTE_W-1:0] i_x,
    input  logic [BYTE_W-1:0] i_a,
    input  logic [BYTE_W-1:0] i_b,
    input  logic [BYTE_W-1:0] i_c,
    output logic [BYTE_W-1:0] o_r
);

    logic [BYTE_W:0]   avg_sum;
    logic signed [9:0] pa;
    logic signed [9:0] pb;
    logic signed [9:0] pc;
    logic [9:0]        pa_abs;
    logic [9:0]        pb_abs;
    logic [9:0]        pc_abs;
    logic [BYTE_W-1:0] paeth;
    logic [BYTE_W-1:0] pred;

    assign avg_sum = {1'b0, i_a} + {1'b0, i_b};

    // p = a + b - c, so p - a = b - c, p - b = a - c, p - c = a + b - 2c
    always_comb begin
        pa = $signed({2'b00, i_b}) - $signed({2'b00, i_c});
        pb = $signed({2'b00, i_a}) - $signed({2'b00, i_c});
        pc = pa + pb;
        pa_abs = pa[9] ? 10'(-pa) : 10'(pa);
        pb_abs = pb[9] ? 10'(-pb) : 10'(pb);
        pc_abs = pc[9] ? 10'(-pc) : 10'(pc);
        if (pa_abs <= pb_abs && pa_abs <= pc_abs) begin
            paeth = i_a;
        end else if (pb_abs <= pc_abs) begin
            paeth = i_b;
        end else begin
            paeth = i_c;
        end
    end

    always_comb begin
        case (i_ctl.filter)
            FILT_NONE:  pred = '0;
            FILT_SUB:   pred = i_a;
            FILT_UP:    pred = i_b;
            FILT_AVG:   pred = avg_sum[BYTE_W:1];
            FILT_PAETH: pred = paeth;
            default:    pred = '0;
        endcase
        if (i_ctl.bad) begin
            pred = '0;
        end
    end

    assign o_r = i_x + pred;

endmodule

/* design/pngu_linebuf.sv */
// ----------------------------------------------------------------------------
// pngu_linebuf
// Previous-row byte store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module pngu_linebuf
    import pngu_pkg::*;
#(
    parameter int DEPTH  = DEF_MAX_WIDTH * DEF_BYTES_PER_PIXEL,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [BYTE_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [BYTE_W-1:0] o_rdata
);

    logic [BYTE_W-1:0] r_mem [DEPTH];
    logic [BYTE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* design/png_scanline_unfilter.sv */
// ----------------------------------------------------------------------------
// png_scanline_unfilter
// PNG filter reconstruction, 8-bit samples, one byte per cycle unless stalled.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_byte) carries the inflated
//   image stream, one byte per beat. The first beat of each row is the filter
//   code; it is consumed and gives no output beat. Every later beat yields one
//   reconstructed byte on the output channel (o_out_valid / i_out_ready) with
//   end-of-row, end-of-image and bad-filter marks.
//   Configuration channel (i_cfg_valid / o_cfg_ready) writes image width
//   (index 0) and height (index 1); it is always ready. Write it only while
//   no data beat is in flight.
//   An accepted data beat passes two register stages, input register then
//   result register, which drives o_out_valid. Throughput: one beat per
//   cycle unless the receiver stalls, set by the single line-buffer port
//   pair (prefetch read at acceptance, write-back as the byte leaves the
//   input register). A row of W pixels takes W*BYTES_PER_PIXEL + 1 beats.
//   Reset clears counters, filter state and valid flags; the block then
//   expects the filter byte of the first row. The line buffer is not cleared:
//   the first row of an image ignores what it reads from it.
//   When the receiver stalls, the result register holds its beat, the input
//   register fills, and o_in_ready drops until the result is taken.
// ----------------------------------------------------------------------------
module png_scanline_unfilter
    import pngu_pkg::*;
#(
    parameter int MAX_WIDTH       = DEF_MAX_WIDTH,
    parameter int BYTES_PER_PIXEL = DEF_BYTES_PER_PIXEL
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // stream input
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [BYTE_W-1:0]     i_in_byte,
    // reconstructed output
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [BYTE_W-1:0]     o_out_byte,
    output logic                  o_end_of_row,
    output logic                  o_end_of_image,
    output logic                  o_bad_filter,
    // configuration writes
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  t_cfg_reg              i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int ROW_BYTES_MAX = MAX_WIDTH * BYTES_PER_PIXEL;
    localparam int ADDR_W = (ROW_BYTES_MAX > 1) ? $clog2(ROW_BYTES_MAX) : 1;
    localparam int CNT_W  = $clog2(ROW_BYTES_MAX + 1);
    localparam int KW     = (BYTES_PER_PIXEL > 1) ? $clog2(BYTES_PER_PIXEL) : 1;

    // configuration
    logic [CFG_WIDTH_W-1:0]  r_cfg_width;
    logic [CFG_HEIGHT_W-1:0] r_cfg_height;

    // row tracking, advanced at acceptance
    logic [CNT_W-1:0]     r_col_cnt;
    logic [ROW_CNT_W-1:0] r_row_cnt;
    logic [KW-1:0]        r_k;
    logic                 r_has_left;
    t_filter              r_row_filter;
    logic                 r_row_bad;

    // input register stage
    logic                 r_in_valid;
    logic [BYTE_W-1:0]    r_in_byte;
    logic [ADDR_W-1:0]    r_in_col;
    logic [KW-1:0]        r_in_k;
    t_pred_ctl            r_in_ctl;
    logic                 r_in_has_left;
    logic                 r_in_has_up;
    logic                 r_in_eor;
    logic                 r_in_eoi;

    // neighbor pixel bytes
    logic [BYTE_W-1:0]    r_left   [BYTES_PER_PIXEL];
    logic [BYTE_W-1:0]    r_upleft [BYTES_PER_PIXEL];

    // result register stage
    logic                 r_out_valid;
    logic [BYTE_W-1:0]    r_out_byte;
    logic                 r_out_eor;
    logic                 r_out_eoi;
    logic                 r_out_bad;

    logic                 in_fire;
    logic                 data_fire;
    logic                 filt_fire;
    logic                 advance;
    logic [CNT_W-1:0]     w_eff;
    logic [CNT_W-1:0]     row_bytes;
    logic [CFG_HEIGHT_W-1:0] h_eff;
    logic [ADDR_W-1:0]    col_full;
    logic                 eor;
    logic                 eoi;
    logic [ROW_CNT_W:0]   row_next;
    logic [BYTE_W-1:0]    up_rdata;
    logic [BYTE_W-1:0]    a_val;
    logic [BYTE_W-1:0]    b_val;
    logic [BYTE_W-1:0]    c_val;
    logic [BYTE_W-1:0]    rebuilt;
    t_pred_ctl            n_ctl;

    // ------------------------------------------------------------------
    // Handshakes: the input register advances whenever the result
    // register is empty or being drained.
    // ------------------------------------------------------------------
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || !r_out_valid || i_out_ready;
    assign in_fire    = i_in_valid && o_in_ready;
    assign filt_fire  = in_fire && (r_col_cnt == '0);
    assign data_fire  = in_fire && (r_col_cnt != '0);
    assign o_cfg_ready = 1'b1;

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= CFG_WIDTH_W'(1);
            r_cfg_height <= CFG_HEIGHT_W'(1);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_IMAGE_WIDTH:  r_cfg_width  <= i_cfg_data[CFG_WIDTH_W-1:0];
                CFG_IMAGE_HEIGHT: r_cfg_height <= i_cfg_data[CFG_HEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp width to 1..MAX_WIDTH and height to at least one row
    always_comb begin
        if (r_cfg_width == '0) begin
            w_eff = CNT_W'(1);
        end else if (32'(r_cfg_width) > 32'(MAX_WIDTH)) begin
            w_eff = CNT_W'(MAX_WIDTH);
        end else begin
            w_eff = CNT_W'(r_cfg_width);
        end
        row_bytes = CNT_W'(32'(w_eff) * 32'(BYTES_PER_PIXEL));
        h_eff     = (r_cfg_height == '0) ? CFG_HEIGHT_W'(1) : r_cfg_height;
    end

    // Marks for the byte being accepted, taken from the pre-increment counts
    assign col_full = ADDR_W'(r_col_cnt - CNT_W'(1));
    assign row_next = {1'b0, r_row_cnt} + (ROW_CNT_W + 1)'(1);
    assign eor      = r_col_cnt >= row_bytes;
    assign eoi      = eor && (row_next >= {1'b0, h_eff});

    // Filter code above the last valid one: pass bytes through, flagged
    always_comb begin
        if (i_in_byte <= FILT_MAX_CODE) begin
            n_ctl.filter = t_filter'(i_in_byte[2:0]);
            n_ctl.bad    = 1'b0;
        end else begin
            n_ctl.filter = FILT_NONE;
            n_ctl.bad    = 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Row and column tracking
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_cnt    <= '0;
            r_row_cnt    <= '0;
            r_k          <= '0;
            r_has_left   <= 1'b0;
            r_row_filter <= FILT_NONE;
            r_row_bad    <= 1'b0;
        end else if (filt_fire) begin
            // filter beat: latch this row's code, start the column walk
            r_row_filter <= n_ctl.filter;
            r_row_bad    <= n_ctl.bad;
            r_col_cnt    <= CNT_W'(1);
            r_k          <= '0;
            r_has_left   <= 1'b0;
        end else if (data_fire) begin
            if (r_k == KW'(BYTES_PER_PIXEL - 1)) begin
                r_k        <= '0;
                r_has_left <= 1'b1;
            end else begin
                r_k <= r_k + KW'(1);
            end
            if (eor) begin
                r_col_cnt <= '0;
                r_row_cnt <= eoi ? '0 : row_next[ROW_CNT_W-1:0];
            end else begin
                r_col_cnt <= r_col_cnt + CNT_W'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // Input register: hold the data beat with its context
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (data_fire) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (data_fire) begin
            r_in_byte     <= i_in_byte;
            r_in_col      <= col_full;
            r_in_k        <= r_k;
            r_in_ctl      <= '{filter: r_row_filter, bad: r_row_bad};
            r_in_has_left <= r_has_left;
            r_in_has_up   <= (r_row_cnt != '0);
            r_in_eor      <= eor;
            r_in_eoi      <= eoi;
        end
    end

    // Prefetch the byte above at acceptance; write back as the byte leaves
    pngu_linebuf #(
        .DEPTH  (ROW_BYTES_MAX),
        .ADDR_W (ADDR_W)
    ) u_linebuf (
        .i_clk   (i_clk),
        .i_we    (advance),
        .i_waddr (r_in_col),
        .i_wdata (rebuilt),
        .i_re    (data_fire),
        .i_raddr (col_full),
        .o_rdata (up_rdata)
    );

    // Neighbors outside the image count as zero
    assign a_val = r_in_has_left ? r_left[r_in_k] : '0;
    assign b_val = r_in_has_up ? up_rdata : '0;
    assign c_val = (r_in_has_left && r_in_has_up) ? r_upleft[r_in_k] : '0;

    pngu_predict u_predict (
        .i_ctl (r_in_ctl),
        .i_x   (r_in_byte),
        .i_a   (a_val),
        .i_b   (b_val),
        .i_c   (c_val),
        .o_r   (rebuilt)
    );

    // Keep the last pixel and the pixel above it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < BYTES_PER_PIXEL; i++) begin
                r_left[i]   <= '0;
                r_upleft[i] <= '0;
            end
        end else if (advance) begin
            r_left[r_in_k]   <= rebuilt;
            r_upleft[r_in_k] <= b_val;
        end
    end

    // ------------------------------------------------------------------
    // Result register: hold the beat until the receiver takes it
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_byte <= rebuilt;
            r_out_eor  <= r_in_eor;
            r_out_eoi  <= r_in_eoi;
            r_out_bad  <= r_in_ctl.bad;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_byte     = r_out_byte;
    assign o_end_of_row   = r_out_eor;
    assign o_end_of_image = r_out_eoi;
    assign o_bad_filter   = r_out_bad;

endmodule
